[src/u8sbc_pkg.sv]
package u8sbc_pkg;

  localparam int BYTE_W = 8;
  localparam int CAP_W = 13;
  localparam int POS_W = 12;
  localparam int MAX_RESULTS = 4;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W = $clog2(MAX_RESULTS);

  localparam int MAX_CAPACITY_DEF = 4096;
  localparam logic [CAP_W-1:0] CAP_RESET = 13'd64;

  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF4;
  localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG = 8'h80;
  localparam logic [BYTE_W-1:0] REPLACEMENT = 8'h3F;
  localparam logic [BYTE_W-1:0] NUL_BYTE = 8'h00;

  // sequence length opened by a lead byte, 0 when b is not a valid lead
  function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b >= LEAD2_LO && b <= LEAD2_HI) begin
      len = 3'd2;
    end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
      len = 3'd3;
    end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

[src/utf8_sanitizing_bounded_copy_unit.sv]
// Channel | Handshake            | Fields                                       | Dir
// --------+----------------------+----------------------------------------------+----
// input   | in_valid, in_ready   | data_byte                                    | in
// result  | out_valid, out_ready | out_byte, out_position, run_last, string_end | out
// config  | cfg_we               | cfg_wdata (output_capacity)                  | in
//
// One source byte is accepted per cycle while each byte yields at most one result and out_ready holds.
// A byte that yields k results (replacement burst or whole sequence, k <= 4)
// occupies the result buffer until all k are taken; the next byte can enter as the last one goes.
// Per-byte decode sits between the sequence state and a 4-entry result buffer.
// Synchronous active-high reset: no sequence open, nothing written, capacity 64.
module utf8_sanitizing_bounded_copy_unit #(
  parameter int unsigned MAX_CAPACITY = u8sbc_pkg::MAX_CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [u8sbc_pkg::CAP_W-1:0]       cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [u8sbc_pkg::BYTE_W-1:0]      data_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [u8sbc_pkg::BYTE_W-1:0]      out_byte,
  output logic [u8sbc_pkg::POS_W-1:0]       out_position,
  output logic                              run_last,
  output logic                              string_end
);

  localparam int CAP_W = u8sbc_pkg::CAP_W;
  localparam int BYTE_W = u8sbc_pkg::BYTE_W;
  localparam int CNT_W = u8sbc_pkg::CNT_W;
  localparam int IDX_W = u8sbc_pkg::IDX_W;
  localparam int NRES = u8sbc_pkg::MAX_RESULTS;

  // configuration and sequence state
  logic [CAP_W-1:0]  capacity;
  logic [CAP_W-1:0]  cap;
  logic [BYTE_W-1:0] held [3];
  logic [1:0]        hc, hc_next;
  logic [2:0]        el, el_next;
  logic [CAP_W-1:0]  wc, wc_next;
  logic              stopped, stopped_next;

  // result buffer
  logic [BYTE_W-1:0] bank [NRES];
  logic [CNT_W-1:0]  rem;
  logic [IDX_W-1:0]  idx;
  logic [CAP_W-1:0]  pos;
  logic              bank_end;

  // decode results
  logic [BYTE_W-1:0] em [NRES];
  logic [CNT_W-1:0]  em_cnt;
  logic              term;
  logic              wr_held;
  logic [1:0]        wr_idx;
  logic              acc;

  logic [CAP_W:0]    wc14, cap14;
  logic [1:0]        wanted;
  logic              fit1, fit2;
  logic [1:0]        fl_cnt;
  logic              fl_stop;
  logic              room_after;
  logic              is_cont;
  logic [2:0]        llen;
  logic [2:0]        f_cnt;
  logic              tail_v;
  logic [BYTE_W-1:0] tail;
  logic              seq_emit;

  assign cap = (32'(capacity) > MAX_CAPACITY) ? CAP_W'(MAX_CAPACITY) : capacity;
  assign wc14 = {1'b0, wc};
  assign cap14 = {1'b0, cap};
  assign is_cont = (data_byte & u8sbc_pkg::CONT_MASK) == u8sbc_pkg::CONT_TAG;
  assign llen = u8sbc_pkg::lead_len(data_byte);

  // replacement burst for a broken sequence: lead always, continuations while room
  always_comb begin
    wanted = (hc == 2'd0) ? 2'd0 : hc - 2'd1;
    fit1 = (wc14 + (CAP_W+1)'(2)) < cap14;
    fit2 = (wc14 + (CAP_W+1)'(3)) < cap14;
    fl_cnt = 2'd1;
    if (wanted != 2'd0 && fit1) begin
      fl_cnt = (wanted == 2'd2 && fit2) ? 2'd3 : 2'd2;
    end
    fl_stop = (fl_cnt - 2'd1) < wanted;
    if (el != 3'd0) begin
      room_after = (wc14 + (CAP_W+1)'(fl_cnt) + (CAP_W+1)'(1)) < cap14;
    end else begin
      room_after = (wc14 + (CAP_W+1)'(1)) < cap14;
    end
  end

  always_comb begin
    hc_next = hc;
    el_next = el;
    wc_next = wc;
    stopped_next = stopped;
    f_cnt = 3'd0;
    tail_v = 1'b0;
    tail = data_byte;
    term = 1'b0;
    seq_emit = 1'b0;
    wr_held = 1'b0;
    wr_idx = hc;
    if (data_byte == u8sbc_pkg::NUL_BYTE) begin
      if (el != 3'd0 && !stopped) begin
        f_cnt = {1'b0, fl_cnt};
      end
      term = cap != '0;
      tail_v = term;
      tail = u8sbc_pkg::NUL_BYTE;
      hc_next = 2'd0;
      el_next = 3'd0;
      wc_next = '0;
      stopped_next = 1'b0;
    end else if (!stopped) begin
      if (el != 3'd0 && is_cont) begin
        if ({1'b0, hc} + 3'd1 >= el) begin
          if ((wc14 + (CAP_W+1)'(el)) < cap14) begin
            seq_emit = 1'b1;
            wc_next = wc + CAP_W'(el);
          end else begin
            stopped_next = 1'b1;
          end
          hc_next = 2'd0;
          el_next = 3'd0;
        end else if (hc < 2'd3) begin
          wr_held = 1'b1;
          hc_next = hc + 2'd1;
        end
      end else begin
        if (el != 3'd0) begin
          f_cnt = {1'b0, fl_cnt};
          wc_next = wc + CAP_W'(fl_cnt);
          stopped_next = fl_stop;
          hc_next = 2'd0;
          el_next = 3'd0;
        end
        if (!(el != 3'd0 && fl_stop)) begin
          if (!room_after) begin
            stopped_next = 1'b1;
          end else if (data_byte < u8sbc_pkg::ASCII_LIMIT) begin
            tail_v = 1'b1;
            wc_next = wc_next + CAP_W'(1);
          end else if (llen != 3'd0) begin
            el_next = llen;
            hc_next = 2'd1;
            wr_held = 1'b1;
            wr_idx = 2'd0;
          end else begin
            tail_v = 1'b1;
            tail = u8sbc_pkg::REPLACEMENT;
            wc_next = wc_next + CAP_W'(1);
          end
        end
      end
    end
  end

  // pack the results of this byte into consecutive slots
  always_comb begin
    for (int i = 0; i < NRES; i++) begin
      if (seq_emit) begin
        if (i == NRES - 1 || 2'(i) == hc) begin
          em[i] = data_byte;
        end else begin
          em[i] = held[i];
        end
      end else begin
        em[i] = (3'(i) < f_cnt) ? u8sbc_pkg::REPLACEMENT : tail;
      end
    end
    if (seq_emit) begin
      em_cnt = CNT_W'(el);
    end else begin
      em_cnt = CNT_W'(f_cnt) + CNT_W'(tail_v);
    end
  end

  assign in_ready = (rem == '0) || (rem == CNT_W'(1) && out_ready);
  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= u8sbc_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hc <= 2'd0;
      el <= 3'd0;
      wc <= '0;
      stopped <= 1'b0;
    end else if (acc) begin
      hc <= hc_next;
      el <= el_next;
      wc <= wc_next;
      stopped <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && wr_held) begin
      held[wr_idx] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      idx <= '0;
    end else if (acc) begin
      rem <= em_cnt;
      idx <= '0;
    end else if (out_valid && out_ready) begin
      rem <= rem - CNT_W'(1);
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      bank <= em;
      pos <= wc;
      bank_end <= term;
    end else if (out_valid && out_ready) begin
      pos <= pos + CAP_W'(1);
    end
  end

  assign out_valid = rem != '0;
  assign out_byte = bank[idx];
  assign out_position = pos[u8sbc_pkg::POS_W-1:0];
  assign run_last = rem == CNT_W'(1);
  assign string_end = bank_end && run_last;

  // a NUL transaction leaves no sequence open and the write count at zero
  a_nul_clears: assert property (@(posedge clk) disable iff (rst)
    acc && data_byte == u8sbc_pkg::NUL_BYTE |=> wc == '0 && el == 3'd0 && !stopped)
    else $error("state not cleared after string end");

  // an open sequence always holds its lead and is not yet complete
  a_open_seq: assert property (@(posedge clk) disable iff (rst)
    el != 3'd0 |-> hc != 2'd0 && {1'b0, hc} < el)
    else $error("held count inconsistent with open sequence");

  // result buffer never holds more than one byte's burst
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    rem <= CNT_W'(NRES))
    else $error("result buffer overfilled");

  // new transaction only when the buffer is empty or empties in this cycle
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    acc |-> rem == '0 || (rem == CNT_W'(1) && out_ready))
    else $error("input accepted over pending results");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int BYTE_W = u8sbc_pkg::BYTE_W;
  localparam int CAP_W = u8sbc_pkg::CAP_W;
  localparam int POS_W = u8sbc_pkg::POS_W;
  localparam int MAX_CAPACITY_DEF = u8sbc_pkg::MAX_CAPACITY_DEF;
  localparam logic [CAP_W-1:0] CAP_RESET = u8sbc_pkg::CAP_RESET;
  localparam logic [BYTE_W-1:0] ASCII_LIMIT = u8sbc_pkg::ASCII_LIMIT;
  localparam logic [BYTE_W-1:0] LEAD2_LO = u8sbc_pkg::LEAD2_LO;
  localparam logic [BYTE_W-1:0] LEAD2_HI = u8sbc_pkg::LEAD2_HI;
  localparam logic [BYTE_W-1:0] LEAD3_LO = u8sbc_pkg::LEAD3_LO;
  localparam logic [BYTE_W-1:0] LEAD3_HI = u8sbc_pkg::LEAD3_HI;
  localparam logic [BYTE_W-1:0] LEAD4_LO = u8sbc_pkg::LEAD4_LO;
  localparam logic [BYTE_W-1:0] LEAD4_HI = u8sbc_pkg::LEAD4_HI;
  localparam logic [BYTE_W-1:0] CONT_MASK = u8sbc_pkg::CONT_MASK;
  localparam logic [BYTE_W-1:0] CONT_TAG = u8sbc_pkg::CONT_TAG;
  localparam logic [BYTE_W-1:0] REPLACEMENT = u8sbc_pkg::REPLACEMENT;
  localparam logic [BYTE_W-1:0] NUL_BYTE = u8sbc_pkg::NUL_BYTE;

  typedef logic [BYTE_W-1:0] u8_t;

  typedef struct packed {
    u8_t               data;
    logic [POS_W-1:0]  pos;
    logic              run_last;
    logic              string_end;
  } write_t;

  typedef enum int {SEG_ASCII, SEG_SEQ, SEG_BROKEN, SEG_BAD_LEAD, SEG_STRAY} seg_kind_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD = 120;
  localparam int PHASE_BYTES = 20;

  // Expected-write tracker: mirrors the sanitizer state and queues the target writes
  // each accepted source byte should produce.
  class sanitized_copy_model_t;
    logic [CAP_W-1:0] capacity;
    u8_t held [3];
    int held_cnt;
    int seq_len;
    int written;
    bit stopped;
    write_t expected_writes[$];
    write_t burst[$];
    int mismatches;
    int bytes_seen;
    int writes_seen;
    int terminators;
    int stops;

    function new();
      capacity = CAP_RESET;
      foreach (held[i]) held[i] = '0;
      restart();
      mismatches = 0;
      bytes_seen = 0;
      writes_seen = 0;
      terminators = 0;
      stops = 0;
    endfunction

    function void restart();
      held_cnt = 0;
      seq_len = 0;
      written = 0;
      stopped = 1'b0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function int cap_limit();
      return (capacity > MAX_CAPACITY_DEF) ? MAX_CAPACITY_DEF : int'(capacity);
    endfunction

    function bit room(int n);
      return (written + n) < cap_limit();
    endfunction

    function void halt();
      if (!stopped) stops++;
      stopped = 1'b1;
    endfunction

    function void emit(u8_t b, bit is_end);
      write_t w;
      w.data = b;
      w.pos = written[POS_W-1:0];
      w.run_last = 1'b0;
      w.string_end = is_end;
      burst.push_back(w);
      if (!is_end) written++;
    endfunction

    // broken sequence: '?' for the lead, then one per held continuation while room lasts
    function void flush_broken();
      emit(REPLACEMENT, 1'b0);
      for (int i = 1; i < held_cnt && i < 3; i++) begin
        if (!room(1)) begin
          halt();
          break;
        end
        emit(REPLACEMENT, 1'b0);
      end
      held_cnt = 0;
      seq_len = 0;
    endfunction

    function void take_lead(u8_t b);
      if (!room(1)) begin
        halt();
        return;
      end
      if (b < ASCII_LIMIT) begin
        emit(b, 1'b0);
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
        seq_len = 2;
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
        seq_len = 3;
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
        seq_len = 4;
      end else begin
        emit(REPLACEMENT, 1'b0);
      end
      if (seq_len != 0) begin
        held[0] = b;
        held_cnt = 1;
      end
    endfunction

    function void accept_byte(u8_t b);
      burst.delete();
      bytes_seen++;
      if (b == NUL_BYTE) begin
        if (seq_len != 0 && !stopped) flush_broken();
        if (cap_limit() > 0) emit(NUL_BYTE, 1'b1);
        restart();
      end else if (!stopped) begin
        if (seq_len != 0 && (b & CONT_MASK) == CONT_TAG) begin
          if (held_cnt + 1 >= seq_len) begin
            // sequence complete: copy it only if the terminator still fits after it
            if (room(seq_len)) begin
              for (int i = 0; i < held_cnt && i < 3; i++) emit(held[i], 1'b0);
              emit(b, 1'b0);
            end else begin
              halt();
            end
            held_cnt = 0;
            seq_len = 0;
          end else if (held_cnt < 3) begin
            held[held_cnt] = b;
            held_cnt++;
          end
        end else begin
          if (seq_len != 0) flush_broken();
          if (!stopped) take_lead(b);
        end
      end
      if (burst.size() > 0) burst[burst.size()-1].run_last = 1'b1;
      foreach (burst[i]) expected_writes.push_back(burst[i]);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 20) $display("MISMATCH: %s", msg);
    endtask

    task check_write(u8_t data, logic [POS_W-1:0] pos, logic last, logic fin);
      write_t want;
      writes_seen++;
      if (expected_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write %02h at %0d", data, pos));
      end else begin
        want = expected_writes.pop_front();
        if (want.string_end) terminators++;
        if (data !== want.data)
          report_mismatch($sformatf("out_byte %02h, want %02h (pos %0d)", data, want.data,
                                    want.pos));
        if (pos !== want.pos)
          report_mismatch($sformatf("out_position %0d, want %0d", pos, want.pos));
        if (last !== want.run_last)
          report_mismatch($sformatf("run_last %b, want %b (pos %0d)", last, want.run_last,
                                    want.pos));
        if (fin !== want.string_end)
          report_mismatch($sformatf("string_end %b, want %b (pos %0d)", fin, want.string_end,
                                    want.pos));
      end
    endtask

    function int pending();
      return expected_writes.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  u8_t               data_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  u8_t               out_byte;
  logic [POS_W-1:0]  out_position;
  logic              run_last;
  logic              string_end;

  sanitized_copy_model_t copy_model = new();

  bit no_gaps = 1'b0;
  int hold_requests = 0;
  int holds_done = 0;
  int cycles = 0;
  int settings_used = 1;
  int phase_bytes = 0;
  int unsigned cap_plan[$] = '{4, 0, 1, 2, 13, 4096, 8191, 4097, 7, 30, 64};

  utf8_sanitizing_bounded_copy_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_position (out_position),
    .run_last     (run_last),
    .string_end   (string_end)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d writes outstanding", cycles,
               copy_model.pending());
      $display("utf8_sanitizing_bounded_copy_unit test failed");
      $finish;
    end
  end

  // input acceptance is noted before the write check so a same-edge result finds its entry
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) copy_model.accept_byte(data_byte);
      if (out_valid && out_ready)
        copy_model.check_write(out_byte, out_position, run_last, string_end);
    end
  end

  function automatic int gap_len();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side: random stalls, plus long hold-offs on request
  initial begin
    int stall;
    int held;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        held = 0;
        while (held < LONG_HOLD) begin
          @(posedge clk);
          held++;
        end
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = gap_len();
      end
    end
  end

  task automatic send_byte(input u8_t b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    phase_bytes++;
  endtask

  task automatic send_list(input u8_t bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  // one edge first so the monitor has noted the last accepted byte
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (copy_model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_capacity(input int unsigned cap);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= CAP_W'(cap);
    @(posedge clk);
    cfg_we <= 1'b0;
    copy_model.set_capacity(CAP_W'(cap));
    settings_used++;
  endtask

  function automatic seg_kind_t pick_segment();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return SEG_ASCII;
    if (roll < 75) return SEG_SEQ;
    if (roll < 87) return SEG_BROKEN;
    if (roll < 94) return SEG_BAD_LEAD;
    return SEG_STRAY;
  endfunction

  function automatic u8_t lead_for(int len);
    case (len)
      2: return u8_t'($urandom_range(LEAD2_LO, LEAD2_HI));
      3: return u8_t'($urandom_range(LEAD3_LO, LEAD3_HI));
      default: return u8_t'($urandom_range(LEAD4_LO, LEAD4_HI));
    endcase
  endfunction

  // mostly well-formed text, with invalid leads, stray continuations and cut sequences
  task automatic send_string();
    int nseg;
    int len;
    int conts;
    seg_kind_t kind;
    nseg = $urandom_range(1, 12);
    for (int s = 0; s < nseg; s++) begin
      kind = pick_segment();
      case (kind)
        SEG_ASCII: send_byte(u8_t'($urandom_range(1, ASCII_LIMIT - 1)));
        SEG_SEQ, SEG_BROKEN: begin
          len = $urandom_range(2, 4);
          conts = (kind == SEG_SEQ) ? len - 1 : $urandom_range(0, len - 2);
          send_byte(lead_for(len));
          repeat (conts) send_byte(CONT_TAG | u8_t'($urandom_range(0, 63)));
        end
        SEG_BAD_LEAD: begin
          if ($urandom_range(0, 1) == 0) send_byte(u8_t'($urandom_range(CONT_MASK, LEAD2_LO - 1)));
          else send_byte(u8_t'($urandom_range(LEAD4_HI + 1, 8'hFF)));
        end
        default: send_byte(CONT_TAG | u8_t'($urandom_range(0, 63)));
      endcase
    end
    send_byte(NUL_BYTE);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset capacity: ASCII extremes, invalid leads, lead range edges, broken sequences
    send_list('{8'h41, 8'h7F, 8'h80, 8'hC0, 8'hF5, 8'hFF,
                8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
                8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hE0, 8'hA0, 8'h41,
                8'hC3, 8'hC3, 8'hA9, 8'hF0, 8'h90, 8'h00});

    foreach (cap_plan[p]) begin
      program_capacity(cap_plan[p]);
      no_gaps = (cap_plan[p] == 4096 || cap_plan[p] == 8191);
      if (cap_plan[p] == 4096) hold_requests++;
      // a four-byte sequence that cannot fit with its terminator
      if (cap_plan[p] == 4) send_list('{8'h41, 8'hF0, 8'h90, 8'h80, 8'h80, 8'h42, 8'h00});
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) send_string();
    end
    no_gaps = 1'b0;

    wait_idle();
    $display("covered %0d source bytes, %0d target writes (%0d terminators)",
             copy_model.bytes_seen, copy_model.writes_seen, copy_model.terminators);
    $display("%0d capacity settings, output stopped early %0d times, %0d mismatches",
             settings_used, copy_model.stops, copy_model.mismatches);
    if (copy_model.mismatches == 0) begin
      $display("utf8_sanitizing_bounded_copy_unit test passed");
    end else begin
      $display("utf8_sanitizing_bounded_copy_unit test failed");
    end
    $finish;
  end

endmodule
